@@ hdl/clut_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap lookup package
// Shared constants, register indexes and word types of the false-color mapper.
// ----------------------------------------------------------------------------
package clut_pkg;

  // Palette storage.
  localparam int PAL_DEPTH = 512;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W;
  localparam int IDX_W    = 9;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int SIZE_W   = 10;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = CH_W + FRAC_W + 2;

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  // Divider and output buffer.
  localparam int DIV_STEPS  = FRAC_W;
  localparam int SKID_DEPTH = 2;
  localparam int SKID_AW    = $clog2(SKID_DEPTH);
  localparam int SKID_CW    = $clog2(SKID_DEPTH + 1);

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MAP   = 1'b1;

  // Register reset values.
  localparam logic signed [SAMPLE_W-1:0] RANGE_MIN_RST    = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] RANGE_MAX_RST    = 16'sd32767;
  localparam logic        [SIZE_W-1:0]   PALETTE_SIZE_RST = 10'd256;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RANGE_MIN    = 2'd0,
    CFG_RANGE_MAX    = 2'd1,
    CFG_PALETTE_SIZE = 2'd2
  } cfg_idx_e;

  // How the normalized position is formed.
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    logic                       req_type;
    logic [IDX_W-1:0]           entry_index;
    logic [CH_W-1:0]            entry_red;
    logic [CH_W-1:0]            entry_green;
    logic [CH_W-1:0]            entry_blue;
    logic signed [SAMPLE_W-1:0] sample;
  } clut_req_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } clut_rsp_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } clut_rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    clut_rgb_t        rgb;
  } clut_wr_t;

  // Word that travels through the divider stages.
  typedef struct packed {
    logic              is_map;
    cls_e              cls;
    logic [MAG_W-1:0]  rem;
    logic [MAG_W-1:0]  den;
    logic [FRAC_W-1:0] quot;
    clut_wr_t          wr;
  } clut_div_t;

endpackage
`default_nettype wire

@@ hdl/colormap_lerp_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap linear interpolation lookup
// False-color mapper: palette writes and sample-to-color mapping through one
// pipelined request channel.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_*): a word with req_type write stores entry_red,
//   entry_green and entry_blue at entry_index and gives no result. A word with
//   req_type map turns sample into one interpolated color word on out_*.
//   Words are accepted when in_valid_i is high and in_stall_o is low.
//   Path: a map word accepted on the request channel passes four normalize
//   stages, the 16-stage restoring divider, three lookup and blend stages
//   and the output buffer before it shows up on out_valid_o. Throughput:
//   one word per cycle while the output buffer has a free slot, as every
//   stage then takes a new word in each cycle.
//   Palette writes and reads both happen in the lookup stage, in request
//   order, so a map may follow a write of the entry it needs directly.
//   Configuration: cfg_we_i writes range_min, range_max or palette_size
//   (index 0, 1, 2); write it only while no word is in flight.
//   Reset: the pipeline and output buffer empty, the registers take their
//   defaults; palette contents stay unknown until written.
//   Stall: a two-word buffer takes results; when it is full the whole
//   pipeline holds and in_stall_o rises. The shown word stays put.
// ----------------------------------------------------------------------------
module colormap_lerp_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire clut_pkg::clut_req_t           in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output clut_pkg::clut_rsp_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [clut_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [clut_pkg::CFG_DW-1:0]   cfg_data_i
);
  import clut_pkg::*;

  logic signed [SAMPLE_W-1:0] range_min_q;
  logic signed [SAMPLE_W-1:0] range_max_q;
  logic [SIZE_W-1:0]          palette_size_q;

  logic      en;
  logic      norm_valid;
  clut_div_t norm_data;
  logic      div_valid;
  clut_div_t div_data;
  logic      lerp_valid;
  clut_rsp_t lerp_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q    <= RANGE_MIN_RST;
      range_max_q    <= RANGE_MAX_RST;
      palette_size_q <= PALETTE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_MIN:    range_min_q    <= $signed(cfg_data_i[SAMPLE_W-1:0]);
        CFG_RANGE_MAX:    range_max_q    <= $signed(cfg_data_i[SAMPLE_W-1:0]);
        CFG_PALETTE_SIZE: palette_size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !en;

  // Range normalization.
  clut_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .data_i      (in_data_i),
    .range_min_i (range_min_q),
    .range_max_i (range_max_q),
    .valid_o     (norm_valid),
    .data_o      (norm_data)
  );

  // Position division.
  clut_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .data_i  (norm_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  // Palette lookup and blend.
  clut_lerp u_lerp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (div_valid),
    .data_i         (div_data),
    .palette_size_i (palette_size_q),
    .valid_o        (lerp_valid),
    .data_o         (lerp_data)
  );

  // Output buffer.
  clut_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lerp_valid),
    .data_i      (lerp_data),
    .ready_o     (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ hdl/clut_norm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap range normalizer
// Input register, offset from the range, sign and magnitude split, and the
// saturation check that feeds the divider.
// ----------------------------------------------------------------------------
module clut_norm (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire clut_pkg::clut_req_t                   data_i,
  input  wire logic signed [clut_pkg::SAMPLE_W-1:0]  range_min_i,
  input  wire logic signed [clut_pkg::SAMPLE_W-1:0]  range_max_i,
  output logic                                       valid_o,
  output clut_pkg::clut_div_t                        data_o
);
  import clut_pkg::*;

  // Stage 1: input register.
  logic      s1_v_q;
  clut_req_t s1_q;

  // Stage 2: offsets from the range minimum.
  logic                     s2_v_q;
  logic                     s2_map_q;
  clut_wr_t                 s2_wr_q;
  logic signed [SAMPLE_W:0] s2_num_q;
  logic signed [SAMPLE_W:0] s2_den_q;
  logic signed [SAMPLE_W:0] num_d;
  logic signed [SAMPLE_W:0] den_d;
  clut_wr_t                 wr_d;

  // Stage 3: magnitudes and class.
  logic             s3_v_q;
  logic             s3_map_q;
  clut_wr_t         s3_wr_q;
  cls_e             s3_cls_q;
  logic [MAG_W-1:0] s3_an_q;
  logic [MAG_W-1:0] s3_ad_q;
  cls_e             cls_d;
  logic signed [SAMPLE_W:0] num_abs;
  logic signed [SAMPLE_W:0] den_abs;
  logic             num_neg;
  logic             den_neg;

  // Stage 4: saturation check.
  logic      s4_v_q;
  clut_div_t s4_q;
  clut_div_t s4_d;

  // Offsets are exact in one extra bit.
  assign num_d = $signed({s1_q.sample[SAMPLE_W-1], s1_q.sample})
               - $signed({range_min_i[SAMPLE_W-1], range_min_i});
  assign den_d = $signed({range_max_i[SAMPLE_W-1], range_max_i})
               - $signed({range_min_i[SAMPLE_W-1], range_min_i});

  always_comb begin
    wr_d.idx       = s1_q.entry_index;
    wr_d.rgb.red   = s1_q.entry_red;
    wr_d.rgb.green = s1_q.entry_green;
    wr_d.rgb.blue  = s1_q.entry_blue;
  end

  // Sign handling: equal bounds, zero offset and opposite signs are settled here.
  assign num_neg = s2_num_q[SAMPLE_W];
  assign den_neg = s2_den_q[SAMPLE_W];
  assign num_abs = num_neg ? -s2_num_q : s2_num_q;
  assign den_abs = den_neg ? -s2_den_q : s2_den_q;

  always_comb begin
    if (s2_den_q == '0) begin
      cls_d = (!num_neg && (s2_num_q != '0)) ? CLS_FULL : CLS_ZERO;
    end else if ((s2_num_q == '0) || (num_neg != den_neg)) begin
      cls_d = CLS_ZERO;
    end else begin
      cls_d = CLS_DIV;
    end
  end

  // A quotient of one or more saturates to the last entry.
  always_comb begin
    s4_d.is_map = s3_map_q;
    s4_d.cls    = ((s3_cls_q == CLS_DIV) && (s3_an_q >= s3_ad_q)) ? CLS_FULL : s3_cls_q;
    s4_d.rem    = s3_an_q;
    s4_d.den    = s3_ad_q;
    s4_d.quot   = '0;
    s4_d.wr     = s3_wr_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q     <= data_i;
      s2_map_q <= (s1_q.req_type == REQ_MAP);
      s2_wr_q  <= wr_d;
      s2_num_q <= num_d;
      s2_den_q <= den_d;
      s3_map_q <= s2_map_q;
      s3_wr_q  <= s2_wr_q;
      s3_cls_q <= cls_d;
      s3_an_q  <= num_abs[MAG_W-1:0];
      s3_ad_q  <= den_abs[MAG_W-1:0];
      s4_q     <= s4_d;
    end
  end

  assign valid_o = s4_v_q;
  assign data_o  = s4_q;

  // A word sent to the divider starts with a remainder below a nonzero divisor.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && s4_q.is_map && (s4_q.cls == CLS_DIV) |-> (s4_q.den != '0) && (s4_q.rem < s4_q.den))
    else $error("divider word starts out of range");

endmodule
`default_nettype wire

@@ hdl/clut_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap position divider
// Restoring division pipeline, one quotient bit per stage, that forms the
// fractional position in the range.
// ----------------------------------------------------------------------------
module clut_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire clut_pkg::clut_div_t  data_i,
  output logic                      valid_o,
  output clut_pkg::clut_div_t       data_o
);
  import clut_pkg::*;

  logic [DIV_STEPS-1:0] v_q;
  clut_div_t            st_q   [DIV_STEPS];
  clut_div_t            step_d [DIV_STEPS];

  // One restoring step: double the remainder, subtract the divisor if it fits.
  function automatic clut_div_t div_step(clut_div_t x);
    logic [MAG_W:0] dbl;
    logic [MAG_W:0] diff;
    logic           ge;
    clut_div_t      y;
    dbl    = {x.rem, 1'b0};
    ge     = (dbl >= {1'b0, x.den});
    diff   = dbl - {1'b0, x.den};
    y      = x;
    y.rem  = ge ? diff[MAG_W-1:0] : dbl[MAG_W-1:0];
    y.quot = {x.quot[FRAC_W-2:0], ge};
    return y;
  endfunction

  // Step logic of each stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign step_d[k] = div_step(data_i);
    end else begin : g_next
      assign step_d[k] = div_step(st_q[k-1]);
    end
  end

  // Valid bits move with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STEPS-2:0], valid_i};
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_q[k] <= step_d[k];
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign data_o  = st_q[DIV_STEPS-1];

  // A finished division leaves a nonzero quotient and a remainder below the divisor.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DIV_STEPS-1] && st_q[DIV_STEPS-1].is_map && (st_q[DIV_STEPS-1].cls == CLS_DIV)
    |-> (st_q[DIV_STEPS-1].quot != '0) && (st_q[DIV_STEPS-1].rem < st_q[DIV_STEPS-1].den))
    else $error("divider result out of range");

endmodule
`default_nettype wire

@@ hdl/clut_lerp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap palette lookup and blend
// Scales the position to the palette, holds the palette memory with two read
// ports, and blends the neighboring entries with rounding.
// ----------------------------------------------------------------------------
module clut_lerp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire clut_pkg::clut_div_t           data_i,
  input  wire logic [clut_pkg::SIZE_W-1:0]   palette_size_i,
  output logic                               valid_o,
  output clut_pkg::clut_rsp_t                data_o
);
  import clut_pkg::*;

  localparam int SCALE_W = FRAC_W + PAL_AW;

  // Highest entry in use, with the size saturated to the storage.
  logic [PAL_AW-1:0] last_idx;

  always_comb begin
    if (32'(palette_size_i) < 2) begin
      last_idx = PAL_AW'(1);
    end else if (32'(palette_size_i) > PAL_DEPTH) begin
      last_idx = PAL_AW'(PAL_DEPTH - 1);
    end else begin
      last_idx = PAL_AW'(palette_size_i - SIZE_W'(1));
    end
  end

  // Stage M: position scaled by the last index.
  logic               m_v_q;
  logic               m_map_q;
  cls_e               m_cls_q;
  clut_wr_t           m_wr_q;
  logic [SCALE_W-1:0] m_scale_q;
  logic [SCALE_W-1:0] scale_d;

  assign scale_d = SCALE_W'(data_i.quot) * SCALE_W'(last_idx);

  // Stage A: palette access.
  logic [PAL_AW-1:0] ra0;
  logic [PAL_AW-1:0] ra1;
  logic [FRAC_W-1:0] frac_d;
  logic              rd_en;
  logic              wr_en;
  logic [PAL_AW-1:0] wr_addr;
  clut_rgb_t         pal_q [PAL_DEPTH];
  clut_rgb_t         rd0_q;
  clut_rgb_t         rd1_q;
  logic              a_v_q;
  logic [FRAC_W-1:0] a_frac_q;

  always_comb begin
    case (m_cls_q)
      CLS_FULL: begin
        ra0    = last_idx;
        ra1    = last_idx;
        frac_d = '0;
      end
      CLS_DIV: begin
        ra0    = m_scale_q[FRAC_W +: PAL_AW];
        ra1    = PAL_AW'(m_scale_q[FRAC_W +: PAL_AW] + 1'b1);
        frac_d = m_scale_q[FRAC_W-1:0];
      end
      default: begin
        ra0    = '0;
        ra1    = '0;
        frac_d = '0;
      end
    endcase
  end

  // Writes and reads happen in the same stage, so they stay in request order.
  assign rd_en   = en_i && m_v_q && m_map_q;
  assign wr_en   = en_i && m_v_q && !m_map_q && (32'(m_wr_q.idx) < PAL_DEPTH);
  assign wr_addr = PAL_AW'(m_wr_q.idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_q[wr_addr] <= m_wr_q.rgb;
    end
    if (rd_en) begin
      rd0_q <= pal_q[ra0];
      rd1_q <= pal_q[ra1];
    end
  end

  // Stage X: channel difference times fraction.
  function automatic logic [CH_W-1:0] chan_of(clut_rgb_t x, int c);
    logic [CH_W-1:0] v;
    case (c)
      0:       v = x.red;
      1:       v = x.green;
      default: v = x.blue;
    endcase
    return v;
  endfunction

  logic                     x_v_q;
  logic [CH_W-1:0]          x_base_q [NUM_CH];
  logic signed [PROD_W-1:0] x_prod_q [NUM_CH];
  logic signed [PROD_W-1:0] prod_d   [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_d[c] = PROD_W'($signed({1'b0, chan_of(rd1_q, c)})
                          - $signed({1'b0, chan_of(rd0_q, c)}))
                * PROD_W'($signed({1'b0, a_frac_q}));
    end
  end

  // Final sum: base plus the rounded blend term.
  logic signed [PROD_W-1:0] round_sum [NUM_CH];
  logic signed [PROD_W-1:0] blend     [NUM_CH];
  logic [CH_W-1:0]          res       [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      round_sum[c] = x_prod_q[c] + $signed(PROD_W'(1) <<< (FRAC_W - 1));
      blend[c]     = $signed({{(PROD_W-CH_W){1'b0}}, x_base_q[c]})
                   + (round_sum[c] >>> FRAC_W);
      res[c]       = blend[c][CH_W-1:0];
    end
  end

  // Valid bits; writes end at the palette.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
      x_v_q <= 1'b0;
    end else if (en_i) begin
      m_v_q <= valid_i;
      a_v_q <= m_v_q && m_map_q;
      x_v_q <= a_v_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_map_q   <= data_i.is_map;
      m_cls_q   <= data_i.cls;
      m_wr_q    <= data_i.wr;
      m_scale_q <= scale_d;
      a_frac_q  <= frac_d;
      for (int c = 0; c < NUM_CH; c++) begin
        x_base_q[c] <= chan_of(rd0_q, c);
        x_prod_q[c] <= prod_d[c];
      end
    end
  end

  assign valid_o          = x_v_q;
  assign data_o.out_red   = res[0];
  assign data_o.out_green = res[1];
  assign data_o.out_blue  = res[2];

  // A palette write never turns into a result.
  a_write_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && m_v_q && !m_map_q |=> !a_v_q)
    else $error("palette write reached the blend stage");

  // The second read is the same entry or the one after it.
  a_read_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (ra1 == ra0) || (ra1 == PAL_AW'(ra0 + 1'b1)))
    else $error("palette reads are not neighbors");

  // Reads stay within the entries in use.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (ra0 <= last_idx) && (ra1 <= last_idx))
    else $error("palette read beyond the last entry");

endmodule
`default_nettype wire

@@ hdl/clut_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colormap output buffer
// Two-word buffer between the pipeline and the result channel; its fill level
// decides when the pipeline advances.
// ----------------------------------------------------------------------------
module clut_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire clut_pkg::clut_rsp_t  data_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output clut_pkg::clut_rsp_t       out_data_o
);
  import clut_pkg::*;

  logic [SKID_CW-1:0] count_q;
  logic [SKID_CW-1:0] count_d;
  logic [SKID_AW-1:0] wr_ptr_q;
  logic [SKID_AW-1:0] rd_ptr_q;
  clut_rsp_t          buf_q [SKID_DEPTH];
  logic               push;
  logic               pop;

  // The pipeline moves only while a slot is free.
  assign ready_o     = (32'(count_q) != SKID_DEPTH);
  assign push        = valid_i && ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = buf_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Buffered words.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire
